### rtl/priority_task_scheduler_stats_top_macros.svh
// Assertion macros for the priority task scheduler checker.
// Depends on nothing; taken in by the checker file.
`ifndef PRIORITY_TASK_SCHEDULER_STATS_TOP_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_STATS_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define PTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pts_pkg.sv
// Shared constants, codes and types of the priority task scheduler.
// Used by the interfaces, the slot cell, the top level and the checker.
package pts_pkg;

	localparam int TASK_SLOTS  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int COUNT_WIDTH = 16;

	localparam int ID_W   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMD_W  = 2;
	localparam int TID_W  = 3;
	localparam int STAT_W = 2;
	localparam int RUN_W  = 3;
	localparam int MASK_W = 8;
	localparam int PEAK_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_POST  = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_BAD  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic              taken;
		logic [ID_W-1:0]   run_id;
		logic              more;
		logic              addr_reg;
		logic              addr_full;
		logic [PEAK_W-1:0] wpk;
		logic [PEAK_W-1:0] bpk;
	} link_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

### rtl/pts_cmd_if.sv
// Command and result channels of the priority task scheduler.
// Depends on pts_pkg for field widths.
interface pts_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [pts_pkg::CMD_W-1:0] command;
	logic [pts_pkg::TID_W-1:0] task_id;

	modport source(output valid, command, task_id, input ready);
	modport sink(input valid, command, task_id, output ready);
endinterface

interface pts_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [pts_pkg::STAT_W-1:0] status;
	logic [pts_pkg::RUN_W-1:0]  run_task;
	logic                      more_ready;
	logic [pts_pkg::PEAK_W-1:0] waiting_peak;
	logic [pts_pkg::PEAK_W-1:0] burst_peak;

	modport source(output valid, status, run_task, more_ready, waiting_peak, burst_peak,
		input ready);
	modport sink(input valid, status, run_task, more_ready, waiting_peak, burst_peak,
		output ready);
endinterface

### rtl/pts_cell.sv
// One task slot: pending counter, and waiting and burst counters with their maxima.
// Passes the priority and lookup link to the next lower slot; uses pts_pkg.
module pts_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  pts_pkg::cmd_t            cmd,
	input  logic                     tid_hit,
	input  logic                     prev_hit,
	input  logic                     registered,
	input  logic                     reg_clear,
	input  logic [pts_pkg::ID_W-1:0] slot_id,
	input  pts_pkg::link_t           link_in,
	output pts_pkg::link_t           link_out
);

	logic [pts_pkg::PEND_W-1:0]      pend_q, pend_n;
	logic [pts_pkg::COUNT_WIDTH-1:0] wait_q, wait_n, wmax_q, wmax_n;
	logic [pts_pkg::COUNT_WIDTH-1:0] burst_q, burst_n, bmax_q, bmax_n;
	logic [pts_pkg::COUNT_WIDTH-1:0] wait_inc, burst_inc;
	logic                            ready, full, sel;

	always_comb begin
		ready     = registered && (pend_q != '0);
		full      = pend_q >= pts_pkg::PEND_W'(pts_pkg::QUEUE_DEPTH);
		sel       = (cmd == pts_pkg::CMD_RUN) && ready && !link_in.taken;
		wait_inc  = pts_pkg::sat_inc(wait_q);
		burst_inc = pts_pkg::sat_inc(burst_q);
		pend_n    = pend_q;
		wait_n    = wait_q;
		wmax_n    = wmax_q;
		burst_n   = burst_q;
		bmax_n    = bmax_q;
		case (cmd)
			pts_pkg::CMD_POST: begin
				if (tid_hit && registered && !full) begin
					pend_n = pend_q + 1'b1;
				end
			end
			pts_pkg::CMD_RUN: begin
				if (ready) begin
					wait_n = wait_inc;
					if (wait_inc > wmax_q) begin
						wmax_n = wait_inc;
					end
				end
				if (sel) begin
					wait_n = '0;
					if (prev_hit) begin
						burst_n = burst_inc;
						if (burst_inc > bmax_q) begin
							bmax_n = burst_inc;
						end
					end
					pend_n = pend_q - 1'b1;
					if (pend_n == '0) begin
						burst_n = '0;
					end
				end
			end
			pts_pkg::CMD_CLEAR: begin
				wmax_n = '0;
				bmax_n = '0;
			end
			default: ;
		endcase

		link_out           = link_in;
		link_out.taken     = link_in.taken | ready;
		link_out.more      = link_in.more | (registered && (pend_n != '0));
		link_out.addr_reg  = link_in.addr_reg | (tid_hit && registered);
		link_out.addr_full = link_in.addr_full | (tid_hit && full);
		if (sel) begin
			link_out.run_id = slot_id;
			link_out.bpk    = pts_pkg::PEAK_W'(bmax_n);
		end
		if ((cmd == pts_pkg::CMD_READ) && tid_hit && registered) begin
			link_out.wpk = pts_pkg::PEAK_W'(wmax_q);
			link_out.bpk = pts_pkg::PEAK_W'(bmax_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			wait_q  <= '0;
			wmax_q  <= '0;
			burst_q <= '0;
			bmax_q  <= '0;
		end else if (reg_clear) begin
			pend_q  <= '0;
			wait_q  <= '0;
			wmax_q  <= '0;
			burst_q <= '0;
			bmax_q  <= '0;
		end else if (fire) begin
			pend_q  <= pend_n;
			wait_q  <= wait_n;
			wmax_q  <= wmax_n;
			burst_q <= burst_n;
			bmax_q  <= bmax_n;
		end
	end

endmodule

### rtl/priority_task_scheduler_stats_top.sv
// Priority task scheduler with starvation and burst statistics.
// The result of a command is registered and shown the cycle after its transfer.
// Throughput: one command per cycle while results are taken; the priority
// chain through the slot cells sets the cycle time.
// Reset clears the task mask, all slot counters and the last run task.
// Depends on pts_pkg, pts_cmd_if, pts_rsp_if and pts_cell.
module priority_task_scheduler_stats_top (
	input  logic                       clk,
	input  logic                       arst_n,
	pts_cmd_if.sink                    cmd,
	pts_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [pts_pkg::MASK_W-1:0] cfg_wdata
);

	localparam int N = pts_pkg::TASK_SLOTS;

	logic [N-1:0]             mask_q, new_mask, reg_clear, tid_hit, prev_hit;
	logic [pts_pkg::ID_W-1:0] prev_q;
	pts_pkg::link_t           link_w [N:1];
	pts_pkg::link_t           fin;
	pts_pkg::cmd_t            op;
	pts_pkg::status_t         status;
	logic                     fire;
	logic                     rsp_valid_q;
	pts_pkg::status_t         status_q;
	logic [pts_pkg::RUN_W-1:0]  run_q;
	logic                     more_q;
	logic [pts_pkg::PEAK_W-1:0] wpk_q, bpk_q;

	assign op        = pts_pkg::cmd_t'(cmd.command);
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign fire      = cmd.valid && cmd.ready;
	assign new_mask  = N'(cfg_wdata) & ~N'(1);
	assign link_w[N] = '0;
	assign fin       = link_w[1];

	assign tid_hit[0]   = 1'b0;
	assign prev_hit[0]  = 1'b0;
	assign reg_clear[0] = 1'b0;

	for (genvar i = 1; i < N; i++) begin : g_slot
		assign tid_hit[i]   = (int'(cmd.task_id) == i);
		assign prev_hit[i]  = (prev_q == pts_pkg::ID_W'(i));
		assign reg_clear[i] = cfg_we && new_mask[i] && !mask_q[i];

		pts_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.fire       (fire),
			.cmd        (op),
			.tid_hit    (tid_hit[i]),
			.prev_hit   (prev_hit[i]),
			.registered (mask_q[i]),
			.reg_clear  (reg_clear[i]),
			.slot_id    (pts_pkg::ID_W'(i)),
			.link_in    (link_w[i+1]),
			.link_out   (link_w[i])
		);
	end

	always_comb begin
		status = pts_pkg::ST_OK;
		case (op)
			pts_pkg::CMD_POST: begin
				if (!fin.addr_reg) begin
					status = pts_pkg::ST_BAD;
				end else if (fin.addr_full) begin
					status = pts_pkg::ST_FULL;
				end
			end
			pts_pkg::CMD_RUN: begin
				if (!fin.taken) begin
					status = pts_pkg::ST_NONE;
				end
			end
			pts_pkg::CMD_READ: begin
				if (!fin.addr_reg) begin
					status = pts_pkg::ST_BAD;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			prev_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mask_q <= new_mask;
			end
			if (fire && (op == pts_pkg::CMD_RUN)) begin
				prev_q <= fin.run_id;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status;
			run_q    <= pts_pkg::RUN_W'(fin.run_id);
			more_q   <= fin.more;
			wpk_q    <= fin.wpk;
			bpk_q    <= fin.bpk;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.run_task     = run_q;
	assign rsp.more_ready   = more_q;
	assign rsp.waiting_peak = wpk_q;
	assign rsp.burst_peak   = bpk_q;

endmodule

### rtl/pts_checker.sv
// Port-level checks of the priority task scheduler, bound to the top level.
// Depends on pts_pkg and priority_task_scheduler_stats_top_macros.svh.
`include "priority_task_scheduler_stats_top_macros.svh"

module pts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [pts_pkg::STAT_W-1:0] rsp_status,
	input logic [pts_pkg::RUN_W-1:0]  rsp_run_task,
	input logic                       rsp_more_ready
);

	`PTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`PTS_ASSERT_NOW(a_stall_only_full, clk, arst_n, !cmd_ready, rsp_valid && !rsp_ready, "command stalled with room")
	`PTS_ASSERT_NEXT(a_cmd_gives_rsp, clk, arst_n, cmd_valid && cmd_ready, rsp_valid, "transfer without result")
	`PTS_ASSERT_NOW(a_run_ok, clk, arst_n, rsp_valid && (rsp_run_task != '0), rsp_status == pts_pkg::ST_OK, "run task with bad status")
	`PTS_ASSERT_NOW(a_none_idle, clk, arst_n, rsp_valid && (rsp_status == pts_pkg::ST_NONE), !rsp_more_ready, "nothing ready yet more ready")

endmodule

bind priority_task_scheduler_stats_top pts_checker u_pts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_run_task   (rsp.run_task),
	.rsp_more_ready (rsp.more_ready)
);

### dv/pts_stats_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the priority task scheduler: watches the mask port and both
// channels, predicts every result and compares it field by field.
// Depends on pts_pkg and the pts_cmd_if / pts_rsp_if channel interfaces.
module pts_stats_checker (
	input  logic               clk,
	input  logic               arst_n,
	pts_cmd_if                 cmd,
	pts_rsp_if                 rsp,
	input  logic               cfg_we,
	input  logic [pts_pkg::MASK_W-1:0] cfg_wdata,
	output int                 errors,
	output int                 outstanding,
	output int                 checked
);
	import pts_pkg::*;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		status_t           status;
		logic [RUN_W-1:0]  run_task;
		logic              more;
		logic [PEAK_W-1:0] wpk;
		logic [PEAK_W-1:0] bpk;
	} sched_result_t;

	logic [MASK_W-1:0] present;
	logic [PEND_W-1:0] pend [TASK_SLOTS];
	count_t            wait_cnt [TASK_SLOTS];
	count_t            wait_max [TASK_SLOTS];
	count_t            burst_cnt [TASK_SLOTS];
	count_t            burst_top [TASK_SLOTS];
	int unsigned       last_run;
	sched_result_t     due_results [$];

	function automatic count_t sat_up(input count_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic bit slot_live(input int unsigned id);
		return id > 0 && id < TASK_SLOTS && present[id];
	endfunction

	function automatic bit slot_waiting(input int unsigned id);
		return slot_live(id) && pend[id] != '0;
	endfunction

	function automatic int unsigned highest_waiting();
		for (int s = TASK_SLOTS - 1; s > 0; s--)
			if (slot_waiting(s))
				return s;
		return 0;
	endfunction

	function automatic void zero_slot(input int s);
		pend[s]      = '0;
		wait_cnt[s]  = '0;
		wait_max[s]  = '0;
		burst_cnt[s] = '0;
		burst_top[s] = '0;
	endfunction

	function automatic void load_mask(input logic [MASK_W-1:0] v);
		logic [MASK_W-1:0] nm;
		nm = v & ~MASK_W'(1);
		for (int s = 1; s < TASK_SLOTS; s++)
			if (nm[s] && !present[s])
				zero_slot(s);
		present = nm;
	endfunction

	function automatic sched_result_t serve_command(input cmd_t op, input logic [TID_W-1:0] tid);
		sched_result_t r;
		int unsigned pick;
		r = '0;
		case (op)
		CMD_POST: begin
			if (!slot_live(tid))
				r.status = ST_BAD;
			else if (pend[tid] >= QUEUE_DEPTH)
				r.status = ST_FULL;
			else
				pend[tid] = pend[tid] + 1'b1;
		end
		CMD_RUN: begin
			for (int s = 1; s < TASK_SLOTS; s++)
				if (slot_waiting(s)) begin
					wait_cnt[s] = sat_up(wait_cnt[s]);
					if (wait_cnt[s] > wait_max[s])
						wait_max[s] = wait_cnt[s];
				end
			pick = highest_waiting();
			if (pick == 0) begin
				r.status = ST_NONE;
			end else begin
				wait_cnt[pick] = '0;
				if (last_run == pick) begin
					burst_cnt[pick] = sat_up(burst_cnt[pick]);
					if (burst_cnt[pick] > burst_top[pick])
						burst_top[pick] = burst_cnt[pick];
				end
				pend[pick] = pend[pick] - 1'b1;
				if (pend[pick] == '0)
					burst_cnt[pick] = '0;
				r.run_task = RUN_W'(pick);
				r.bpk      = burst_top[pick];
			end
			last_run = pick;
		end
		CMD_CLEAR: begin
			for (int s = 0; s < TASK_SLOTS; s++) begin
				wait_max[s]  = '0;
				burst_top[s] = '0;
			end
		end
		CMD_READ: begin
			if (!slot_live(tid)) begin
				r.status = ST_BAD;
			end else begin
				r.wpk = wait_max[tid];
				r.bpk = burst_top[tid];
			end
		end
		default: ;
		endcase
		r.more = highest_waiting() != 0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : score
		sched_result_t want;
		sched_result_t seen;
		int bad;
		int delta;
		if (!arst_n) begin
			present = '0;
			for (int s = 0; s < TASK_SLOTS; s++)
				zero_slot(s);
			last_run = 0;
			due_results.delete();
			errors      <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			bad   = 0;
			delta = 0;
			if (cfg_we)
				load_mask(cfg_wdata);
			if (rsp.valid && rsp.ready) begin
				seen.status   = status_t'(rsp.status);
				seen.run_task = rsp.run_task;
				seen.more     = rsp.more_ready;
				seen.wpk      = rsp.waiting_peak;
				seen.bpk      = rsp.burst_peak;
				if (due_results.size() == 0) begin
					$error("result transfer with no command waiting");
					bad++;
				end else begin
					want = due_results.pop_front();
					delta--;
					if (seen.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, seen.status);
						bad++;
					end
					if (seen.run_task !== want.run_task) begin
						$error("run_task: expected %0d, got %0d", want.run_task, seen.run_task);
						bad++;
					end
					if (seen.more !== want.more) begin
						$error("more_ready: expected %0d, got %0d", want.more, seen.more);
						bad++;
					end
					if (seen.wpk !== want.wpk) begin
						$error("waiting_peak: expected %0d, got %0d", want.wpk, seen.wpk);
						bad++;
					end
					if (seen.bpk !== want.bpk) begin
						$error("burst_peak: expected %0d, got %0d", want.bpk, seen.bpk);
						bad++;
					end
				end
				checked <= checked + 1;
			end
			if (cmd.valid && cmd.ready) begin
				due_results.push_back(serve_command(cmd_t'(cmd.command), cmd.task_id));
				delta++;
			end
			errors      <= errors + bad;
			outstanding <= outstanding + delta;
		end
	end

endmodule

### dv/tb_priority_task_scheduler_stats_top.sv
`timescale 1ns / 1ps
// Top of the priority task scheduler testbench: clock, reset, mask writes,
// command stimulus under several idle and stall mixes, and the verdict.
// Depends on pts_pkg, the channel interfaces, the block and pts_stats_checker.
module tb_priority_task_scheduler_stats_top;
	import pts_pkg::*;

	localparam int HOLD_CYCLES = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int TID_MAX     = (1 << TID_W) - 1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [MASK_W-1:0] cfg_wdata;
	logic [MASK_W-1:0] cur_mask;
	int                send_idle_pct;
	int                recv_stall_pct;
	logic              hold_req;
	logic              hold_done;
	int                hold_left;
	int                quiet;
	int                sent;
	int                settings;
	int                errors;
	int                outstanding;
	int                checked;

	pts_cmd_if cmd_ch();
	pts_rsp_if rsp_ch();

	priority_task_scheduler_stats_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	pts_stats_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.errors     (errors),
		.outstanding(outstanding),
		.checked    (checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_req && !hold_done) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
		end else if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			rsp_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_priority_task_scheduler_stats_top: errors");
				$finish;
			end
		end
	end

	task automatic issue(input cmd_t op, input logic [TID_W-1:0] tid);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.task_id <= tid;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mask  = v;
		settings++;
	endtask

	task automatic random_item(input int post_pct, input int run_pct);
		int r;
		cmd_t op;
		logic [TID_W-1:0] tid;
		r = $urandom_range(0, 99);
		if (r < post_pct)
			op = CMD_POST;
		else if (r < post_pct + run_pct)
			op = CMD_RUN;
		else if (r < 96)
			op = CMD_READ;
		else
			op = CMD_CLEAR;
		tid = TID_W'($urandom_range(0, TID_MAX));
		// mostly address registered slots so queues fill and drain
		if ($urandom_range(0, 99) < 80 && cur_mask[MASK_W-1:1] != '0)
			while (tid == 0 || !cur_mask[tid])
				tid = TID_W'($urandom_range(1, TID_MAX));
		issue(op, tid);
	endtask

	task automatic run_phase(input logic [MASK_W-1:0] m, input int n, input int idle,
			input int stall, input int post_pct, input int run_pct, input bit with_hold);
		write_mask(m);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == n / 4)
				hold_req = 1'b1;
			random_item(post_pct, run_pct);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		cur_mask       = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_POST;
		cmd_ch.task_id = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		sent           = 0;
		settings       = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing registered yet
		issue(CMD_RUN, 0);
		issue(CMD_POST, 3);
		issue(CMD_READ, 5);
		write_mask(8'hFF);
		issue(CMD_POST, 0);
		issue(CMD_READ, 0);
		// fill slot 1 one past its depth
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			issue(CMD_POST, 1);
		issue(CMD_POST, 7);
		issue(CMD_POST, 7);
		issue(CMD_RUN, 2);
		issue(CMD_RUN, 4);
		issue(CMD_RUN, 6);
		issue(CMD_READ, 7);
		issue(CMD_READ, 1);
		issue(CMD_CLEAR, 7);
		issue(CMD_READ, 7);

		run_phase(8'hFF, 200, 0, 0, 45, 35, 1'b1);
		run_phase(8'h00, 20, 37, 37, 45, 35, 1'b0);
		run_phase(8'hAA, 180, 55, 0, 40, 45, 1'b0);
		run_phase(8'hFE, 180, 0, 55, 50, 30, 1'b0);
		run_phase(8'h55, 160, 37, 37, 30, 55, 1'b0);
		run_phase(8'hFF, 160, 0, 0, 45, 40, 1'b0);
		settle();
		repeat (4) @(posedge clk);

		$display("run covered %0d commands under %0d mask settings, %0d results compared",
			sent, settings, checked);
		$display("idle mixes: none, sender 55%%, receiver 55%%, both 37%%, one long hold-off");
		if (errors == 0)
			$display("tb_priority_task_scheduler_stats_top: clean");
		else
			$display("tb_priority_task_scheduler_stats_top: errors");
		$finish;
	end

endmodule
